[src/quoted_decimal_pair_parser_assert.svh]
// Assertion macros shared by the quoted decimal pair parser RTL.
// Depends on nothing; included by the top level only.
`ifndef QUOTED_DECIMAL_PAIR_PARSER_ASSERT_SVH
`define QUOTED_DECIMAL_PAIR_PARSER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define QDPP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define QDPP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/qdpp_pkg.sv]
// Package for the quoted decimal pair parser: payload structs, job format,
// character codes and the scale-by-ten helpers. Depends on nothing.
`timescale 1ns / 1ps

package qdpp_pkg;

   localparam int unsigned FractionDigits = 9;
   // Digit counter width covers the largest supported fraction length (18).
   localparam int unsigned CountWidth     = 5;
   localparam int unsigned QueueDepth     = 4;

   localparam logic [7:0] CharQuote = 8'd34;
   localparam logic [7:0] CharPoint = 8'd46;
   localparam logic [7:0] CharZero  = 8'd48;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic [63:0] price_value;
      logic [63:0] qty_value;
   } rsp_type;

   // One finished number still to be scaled: integer part, raw fraction digits.
   typedef struct packed {
      logic                  is_qty;
      logic [63:0]           whole;
      logic [63:0]           frac;
      logic [CountWidth-1:0] count;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic full;
      logic valid;
   } fifo_status_type;

   function automatic logic [63:0] times_ten(input logic [63:0] x);
      return (x << 3) + (x << 1);
   endfunction

   // One step of the scale pipeline: whole part always times ten, fraction
   // times ten only while it still lacks padding digits.
   function automatic job_type scale_step(input job_type j, input int unsigned step,
                                          input int unsigned digits);
      job_type r;
      r = j;
      r.whole = times_ten(j.whole);
      if (step + 32'(j.count) < digits) begin
         r.frac = times_ten(j.frac);
      end
      return r;
   endfunction

endpackage

[src/qdpp_front.sv]
// Front end: byte scanner, quote tracking and digit accumulation.
// Depends on qdpp_pkg; pushes finished numbers into the job queue.
`timescale 1ns / 1ps

module qdpp_front #(
   parameter int unsigned FRACTION_DIGITS = qdpp_pkg::FractionDigits
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_accept,
   input  qdpp_pkg::req_type  req_data,
   output qdpp_pkg::push_type job_push
);

   localparam logic [1:0] PhaseSeekPrice = 2'd0;
   localparam logic [1:0] PhasePrice     = 2'd1;
   localparam logic [1:0] PhaseSeekQty   = 2'd2;
   localparam logic [1:0] PhaseQty       = 2'd3;

   localparam int unsigned CW = qdpp_pkg::CountWidth;

   logic [1:0]    phase_ff, phase_in;
   logic [63:0]   whole_ff, whole_in;
   logic [63:0]   frac_ff, frac_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          point_ff, point_in;

   logic          is_quote;
   logic          is_point;
   logic [63:0]   offset;

   assign is_quote = (req_data.text_byte == qdpp_pkg::CharQuote);
   assign is_point = (req_data.text_byte == qdpp_pkg::CharPoint);
   // non-digits contribute their signed distance from '0', wrapping
   assign offset   = {56'd0, req_data.text_byte} - {56'd0, qdpp_pkg::CharZero};

   always_comb begin
      phase_in = phase_ff;
      whole_in = whole_ff;
      frac_in  = frac_ff;
      cnt_in   = cnt_ff;
      point_in = point_ff;
      job_push.valid      = 1'b0;
      job_push.job.is_qty = (phase_ff == PhaseQty);
      job_push.job.whole  = whole_ff;
      job_push.job.frac   = frac_ff;
      job_push.job.count  = cnt_ff;
      if (req_accept) begin
         if (req_data.stream_end) begin
            phase_in = PhaseSeekPrice;
            whole_in = '0;
            frac_in  = '0;
            cnt_in   = '0;
            point_in = 1'b0;
         end else begin
            case (phase_ff)
               PhaseSeekPrice, PhaseSeekQty: begin
                  if (is_quote) begin
                     whole_in = '0;
                     frac_in  = '0;
                     cnt_in   = '0;
                     point_in = 1'b0;
                     phase_in = (phase_ff == PhaseSeekPrice) ? PhasePrice : PhaseQty;
                  end
               end
               PhasePrice, PhaseQty: begin
                  if (is_quote) begin
                     job_push.valid = 1'b1;
                     whole_in = '0;
                     frac_in  = '0;
                     cnt_in   = '0;
                     point_in = 1'b0;
                     phase_in = (phase_ff == PhasePrice) ? PhaseSeekQty : PhaseSeekPrice;
                  end else if (!point_ff) begin
                     if (is_point) begin
                        point_in = 1'b1;
                     end else begin
                        whole_in = qdpp_pkg::times_ten(whole_ff) + offset;
                     end
                  end else if (cnt_ff < CW'(FRACTION_DIGITS)) begin
                     frac_in = qdpp_pkg::times_ten(frac_ff) + offset;
                     cnt_in  = cnt_ff + CW'(1);
                  end
               end
               default: begin
                  phase_in = PhaseSeekPrice;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhaseSeekPrice;
         whole_ff <= '0;
         frac_ff  <= '0;
         cnt_ff   <= '0;
         point_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         whole_ff <= whole_in;
         frac_ff  <= frac_in;
         cnt_ff   <= cnt_in;
         point_ff <= point_in;
      end
   end

endmodule

[src/qdpp_fifo.sv]
// Short job queue between the scanner and the scale pipeline.
// Depends on qdpp_pkg for the job format.
`timescale 1ns / 1ps

module qdpp_fifo #(
   parameter int unsigned DEPTH = qdpp_pkg::QueueDepth
) (
   input  logic                      clock,
   input  logic                      reset,
   input  qdpp_pkg::push_type        push,
   input  logic                      pop,
   output qdpp_pkg::fifo_status_type status,
   output qdpp_pkg::job_type         head
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   qdpp_pkg::job_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign status = '{full: (count_ff == CW'(DEPTH)), valid: (count_ff != '0)};
   assign head   = entry_ff[rd_ptr_ff];

   assign do_push = push.valid && !status.full;
   assign do_pop  = pop && status.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

[src/qdpp_back.sv]
// Back end: scale pipeline (one times-ten step per stage), final add,
// held price and the result register. Depends on qdpp_pkg.
`timescale 1ns / 1ps

module qdpp_back #(
   parameter int unsigned FRACTION_DIGITS = qdpp_pkg::FractionDigits
) (
   input  logic              clock,
   input  logic              reset,
   input  qdpp_pkg::job_type head,
   input  logic              head_valid,
   output logic              head_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output qdpp_pkg::rsp_type rsp_data
);

   localparam int unsigned F = FRACTION_DIGITS;

   qdpp_pkg::job_type stage_ff [F];
   logic [F-1:0]      stage_valid_ff;
   logic [63:0]       held_price_ff;
   logic              out_valid_ff;
   qdpp_pkg::rsp_type out_data_ff;

   qdpp_pkg::job_type last;
   logic [63:0]       sum;
   logic              advance;

   assign last     = stage_ff[F-1];
   assign sum      = last.whole + last.frac;
   // the whole pipe moves together whenever the result slot is free or draining
   assign advance  = !out_valid_ff || rsp_pop;
   assign head_pop = advance && head_valid;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
         out_valid_ff   <= 1'b0;
      end else if (advance) begin
         stage_valid_ff[0] <= head_valid;
         for (int k = 1; k < F; k++) begin
            stage_valid_ff[k] <= stage_valid_ff[k-1];
         end
         out_valid_ff <= stage_valid_ff[F-1] && last.is_qty;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff[0] <= qdpp_pkg::scale_step(head, 0, F);
         for (int k = 1; k < F; k++) begin
            stage_ff[k] <= qdpp_pkg::scale_step(stage_ff[k-1], k, F);
         end
         if (stage_valid_ff[F-1]) begin
            if (last.is_qty) begin
               out_data_ff.price_value <= held_price_ff;
               out_data_ff.qty_value   <= sum;
            end else begin
               held_price_ff <= sum;
            end
         end
      end
   end

endmodule

[src/quoted_decimal_pair_parser.sv]
// Quoted decimal pair parser, top level. Uses qdpp_pkg, qdpp_front, qdpp_fifo, qdpp_back.
// Throughput: one byte per cycle while the job queue is not full; each pair is two jobs.
// The quantity's closing quote pushes a job that passes through the job queue,
//   the times-ten scale pipeline and the final add into the result register.
// Reset: synchronous, active high; clears scan state, queue and result slot.
`timescale 1ns / 1ps
`include "quoted_decimal_pair_parser_assert.svh"

module quoted_decimal_pair_parser #(
   parameter int unsigned FRACTION_DIGITS = qdpp_pkg::FractionDigits,
   parameter int unsigned QUEUE_DEPTH     = qdpp_pkg::QueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   // input channel: one transaction per text byte
   input  logic              req_push,
   output logic              req_full,
   input  qdpp_pkg::req_type req_data,
   // result channel: one transaction per price/quantity pair
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output qdpp_pkg::rsp_type rsp_data
);

   // Structure:
   //   front - tracks which quoted string we are in and accumulates the
   //           integer and fraction digits of the current string. On a
   //           closing quote it pushes the raw number as a job.
   //   fifo  - a few jobs of slack so the scanner keeps taking bytes while
   //           the result side is stalled.
   //   back  - scales each job by 10^FRACTION_DIGITS (whole) and pads the
   //           fraction, one multiply-by-ten per stage, then adds. Prices
   //           are held; a quantity pairs with the held price.
   //
   // An end-of-stream transaction only resets the scanner. Jobs already in
   // flight are complete numbers, and every quantity is preceded by a price
   // job pushed after the last end-of-stream, so the held price is always
   // the right one.

   logic                      req_accept;
   qdpp_pkg::push_type        job_push;
   qdpp_pkg::fifo_status_type fifo_status;
   qdpp_pkg::job_type         fifo_head;
   logic                      fifo_pop;
   logic                      end_accept;
   logic                      queue_idle;

   // the scanner stalls as a whole when the job queue is full
   assign req_full   = fifo_status.full;
   assign req_accept = req_push && !req_full;

   qdpp_front #(
      .FRACTION_DIGITS(FRACTION_DIGITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .job_push   (job_push)
   );

   qdpp_fifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (job_push),
      .pop    (fifo_pop),
      .status (fifo_status),
      .head   (fifo_head)
   );

   qdpp_back #(
      .FRACTION_DIGITS(FRACTION_DIGITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (fifo_head),
      .head_valid (fifo_status.valid),
      .head_pop   (fifo_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

   assign end_accept = req_accept && req_data.stream_end;
   assign queue_idle = !fifo_status.valid && !job_push.valid;

   // A job is only produced by an accepted byte, never on end-of-stream,
   // and never into a full queue.
   `QDPP_ASSERT_IMPLY(a_push_on_accept, clock, reset, job_push.valid, req_accept, "stray job")
   `QDPP_ASSERT_IMPLY(a_no_push_on_end, clock, reset, end_accept, !job_push.valid, "job on end")
   `QDPP_ASSERT_IMPLY(a_no_overflow, clock, reset, job_push.valid, !fifo_status.full, "overflow")
   // an empty queue stays empty unless a job arrives
   `QDPP_ASSERT_NEXT(a_queue_stays_empty, clock, reset, queue_idle, !fifo_status.valid, "bad fill")

endmodule

[verif/quoted_decimal_pair_parser_checker.sv]
// Scoreboard for the quoted decimal pair parser: watches both queue ports,
// predicts each price/quantity pair and compares. Depends on qdpp_pkg.
`timescale 1ns / 1ps

module quoted_decimal_pair_parser_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  qdpp_pkg::req_type req_data,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  qdpp_pkg::rsp_type rsp_data,
   output int unsigned       pairs_pending,
   output int unsigned       fail_count
);

   localparam logic [1:0] SeekPrice = 2'd0;
   localparam logic [1:0] InPrice   = 2'd1;
   localparam logic [1:0] SeekQty   = 2'd2;
   localparam logic [1:0] InQty     = 2'd3;

   logic [1:0]        phase;
   logic [63:0]       whole_acc;
   logic [63:0]       frac_acc;
   logic [4:0]        frac_count;
   logic              point_seen;
   logic [63:0]       price_hold;
   qdpp_pkg::rsp_type pair_queue[$];

   function automatic logic [63:0] ten_power(input int unsigned n);
      logic [63:0] p;
      p = 64'd1;
      repeat (n) p = p * 64'd10;
      return p;
   endfunction

   task automatic clear_number();
      whole_acc  = '0;
      frac_acc   = '0;
      frac_count = '0;
      point_seen = 1'b0;
   endtask

   // Fixed-point value of the string parsed so far; short fractions get padded.
   function automatic logic [63:0] number_value();
      logic [63:0] frac_part;
      frac_part = '0;
      if (point_seen) begin
         frac_part = frac_acc * ten_power(qdpp_pkg::FractionDigits - frac_count);
      end
      return whole_acc * ten_power(qdpp_pkg::FractionDigits) + frac_part;
   endfunction

   // Any byte inside a string is a digit; non-digits add a signed offset.
   task automatic add_digit(input logic [7:0] b);
      logic [63:0] offset;
      offset = {56'd0, b} - {56'd0, qdpp_pkg::CharZero};
      if (!point_seen) begin
         if (b == qdpp_pkg::CharPoint) begin
            point_seen = 1'b1;
         end else begin
            whole_acc = whole_acc * 64'd10 + offset;
         end
      end else if (frac_count < qdpp_pkg::FractionDigits) begin
         frac_acc   = frac_acc * 64'd10 + offset;
         frac_count = frac_count + 5'd1;
      end
   endtask

   task automatic parse_byte(input qdpp_pkg::req_type t);
      qdpp_pkg::rsp_type pair;
      if (t.stream_end) begin
         phase = SeekPrice;
         clear_number();
         price_hold = '0;
      end else begin
         case (phase)
            SeekPrice, SeekQty: begin
               if (t.text_byte == qdpp_pkg::CharQuote) begin
                  clear_number();
                  if (phase == SeekPrice) phase = InPrice;
                  else phase = InQty;
               end
            end
            InPrice: begin
               if (t.text_byte == qdpp_pkg::CharQuote) begin
                  price_hold = number_value();
                  clear_number();
                  phase = SeekQty;
               end else begin
                  add_digit(t.text_byte);
               end
            end
            default: begin
               if (t.text_byte == qdpp_pkg::CharQuote) begin
                  pair.price_value = price_hold;
                  pair.qty_value   = number_value();
                  pair_queue.push_back(pair);
                  clear_number();
                  phase = SeekPrice;
               end else begin
                  add_digit(t.text_byte);
               end
            end
         endcase
      end
   endtask

   always @(posedge clock) begin : watch_channels
      qdpp_pkg::rsp_type want;
      if (reset) begin
         phase = SeekPrice;
         clear_number();
         price_hold = '0;
         pair_queue.delete();
         fail_count = 0;
      end else begin
         // a pair leaving now was predicted on an earlier edge
         if (rsp_pop && !rsp_empty) begin
            if (pair_queue.size() == 0) begin
               $error("unexpected pair: price_value %h qty_value %h",
                      rsp_data.price_value, rsp_data.qty_value);
               fail_count++;
            end else begin
               want = pair_queue.pop_front();
               if (rsp_data.price_value !== want.price_value) begin
                  $error("price_value mismatch: expected %h, got %h",
                         want.price_value, rsp_data.price_value);
                  fail_count++;
               end
               if (rsp_data.qty_value !== want.qty_value) begin
                  $error("qty_value mismatch: expected %h, got %h",
                         want.qty_value, rsp_data.qty_value);
                  fail_count++;
               end
            end
         end
         if (req_push && !req_full) parse_byte(req_data);
      end
      pairs_pending = pair_queue.size();
   end

endmodule

[verif/quoted_decimal_pair_parser_test.sv]
// Testbench top for the quoted decimal pair parser: clock, reset, byte stimulus,
// result-side stalls, watchdog and verdict. Depends on qdpp_pkg and the checker.
`timescale 1ns / 1ps

module quoted_decimal_pair_parser_test;

   // Longest stretch with no transaction on either side before giving up.
   localparam int unsigned StallLimit    = 2000;
   // Settle time after the last pair: well past the scale pipeline.
   localparam int unsigned SettleCycles  = 40;
   localparam int unsigned ItemsPerPhase = 400;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_push  = 1'b0;
   logic              req_full;
   qdpp_pkg::req_type req_data  = '0;
   logic              rsp_empty;
   logic              rsp_pop   = 1'b0;
   qdpp_pkg::rsp_type rsp_data;

   int unsigned pairs_pending;
   int unsigned fail_count;
   int unsigned push_idle_pct = 0;
   int unsigned pop_stall_pct = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned text_items    = 0;

   // Idle percentages per phase: none, sender only, receiver only, both.
   int unsigned idle_plan[4]  = '{0, 48, 0, 15};
   int unsigned stall_plan[4] = '{0, 0, 48, 15};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   quoted_decimal_pair_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   quoted_decimal_pair_parser_checker watch (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data      (req_data),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_data      (rsp_data),
      .pairs_pending (pairs_pending),
      .fail_count    (fail_count)
   );

   // Receiver: pop decided once per falling edge, so stalls hit every phase.
   always @(negedge clock) begin
      rsp_pop = ($urandom_range(99) >= pop_stall_pct);
   end

   // Watchdog: counts edges at which neither side completes a transaction.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= StallLimit) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // One input transaction. Push is only ever set once per falling edge;
   // it stays high across back-to-back transactions.
   task automatic send_item(input logic [7:0] b, input logic e);
      @(negedge clock);
      while ($urandom_range(99) < push_idle_pct) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push            = 1'b1;
      req_data.text_byte  = b;
      req_data.stream_end = e;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (!e) text_items++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   function automatic logic [7:0] non_quote_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == qdpp_pkg::CharQuote);
      return b;
   endfunction

   task automatic send_digit();
      send_item(qdpp_pkg::CharZero + 8'($urandom_range(9)), 1'b0);
   endtask

   // Body of one quoted string, quotes excluded. Half are ordinary decimals; the rest
   // hit empty bodies, a lone point, wraparound, stray bytes and doubled points.
   task automatic send_number();
      int unsigned kind;
      kind = $urandom_range(9);
      case (kind)
         0: ;  // empty string
         1: send_item(qdpp_pkg::CharPoint, 1'b0);
         2: begin
            // long integer part, which can wrap the 64-bit accumulator
            repeat ($urandom_range(25, 15)) send_digit();
            if ($urandom_range(1) == 1) begin
               send_item(qdpp_pkg::CharPoint, 1'b0);
               repeat ($urandom_range(12)) send_digit();
            end
         end
         3: begin
            repeat ($urandom_range(8, 1)) begin
               if ($urandom_range(2) == 0) send_item(non_quote_byte(), 1'b0);
               else send_digit();
            end
         end
         4: begin
            repeat ($urandom_range(3)) send_digit();
            send_item(qdpp_pkg::CharPoint, 1'b0);
            repeat ($urandom_range(4)) send_digit();
            send_item(qdpp_pkg::CharPoint, 1'b0);
            repeat ($urandom_range(6)) send_digit();
         end
         default: begin
            repeat ($urandom_range(6)) send_digit();
            if ($urandom_range(3) != 0) begin
               send_item(qdpp_pkg::CharPoint, 1'b0);
               repeat ($urandom_range(11)) send_digit();
            end
         end
      endcase
   endtask

   task automatic send_junk();
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(3, 1)) send_item(non_quote_byte(), 1'b0);
      end
   endtask

   // A well-formed price/quantity pair with random content; now and then the
   // stream ends inside the quantity so the partial pair gets dropped.
   task automatic send_pair();
      send_junk();
      send_item(qdpp_pkg::CharQuote, 1'b0);
      send_number();
      send_item(qdpp_pkg::CharQuote, 1'b0);
      send_junk();
      send_item(qdpp_pkg::CharQuote, 1'b0);
      send_number();
      if ($urandom_range(11) == 0) begin
         send_item(8'($urandom_range(255)), 1'b1);
      end else begin
         send_item(qdpp_pkg::CharQuote, 1'b0);
      end
   endtask

   // Raw noise: any byte, with the occasional end-of-stream mark.
   task automatic send_noise();
      repeat ($urandom_range(10, 3)) begin
         send_item(8'($urandom_range(255)), ($urandom_range(15) == 0));
      end
   endtask

   // Hold the sender off until every predicted pair has been popped.
   task automatic drain_pairs();
      @(negedge clock);
      req_push = 1'b0;
      while (pairs_pending != 0) @(negedge clock);
   endtask

   initial begin
      int unsigned target;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: end mark while idle, bytes outside strings, empty price,
      // a non-digit and a second point, excess fraction digits, an
      // integer-only quantity, then a price cut off by the end mark.
      send_item(8'hFF, 1'b1);
      send_item(8'h00, 1'b0);
      send_text("\"\"");
      send_item(8'hFF, 1'b0);
      send_text("\"A..\"");
      send_text("\"0.1234567890\"\"9\"");
      send_text("\"5");
      send_item(qdpp_pkg::CharQuote, 1'b1);
      drain_pairs();

      for (int p = 0; p < 4; p++) begin
         push_idle_pct = idle_plan[p];
         pop_stall_pct = stall_plan[p];
         target = text_items + ItemsPerPhase;
         while (text_items < target) begin
            if ($urandom_range(9) == 0) send_noise();
            else send_pair();
         end
         drain_pairs();
      end

      // Everything predicted has come out; give a stray extra pair time to show.
      repeat (SettleCycles) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
